// ===== sv/pts_pkg.sv =====
// ---------------------------------------------------------------------------
// pts_pkg : shared types and codes for the phased periodic task scheduler
// Request and response beats, command codes, status codes and the command and
// status bundles that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

   localparam int MaxActionsDefault = 16;
   localparam int TimeBitsDefault   = 32;

   localparam logic [1:0] CmdAdd    = 2'd0;
   localparam logic [1:0] CmdRemove = 2'd1;
   localparam logic [1:0] CmdTick   = 2'd2;
   localparam logic [1:0] CmdNext   = 2'd3;

   localparam logic [1:0] StatusOk      = 2'd0;
   localparam logic [1:0] StatusFull    = 2'd1;
   localparam logic [1:0] StatusNoGrant = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] period;
      logic [15:0] phase;
      logic [15:0] target_id;
      logic [31:0] time_amount;
   } pts_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] action_id;
      logic [31:0] budget;
      logic [4:0]  due_count;
      logic        last_grant;
   } pts_rsp_type;

   typedef struct packed {
      logic [15:0] id;
      logic [15:0] period;
      logic [15:0] phase;
   } pts_slot_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;
      logic add_do;
      logic scan_init;
      logic rd_table;
      logic rm_step;
      logic rm_commit;
      logic tick_init;
      logic tick_fin;
      logic div_mod_start;
      logic mod_step;
      logic idx_inc;
      logic nogrant;
      logic next_start;
      logic grant_fin;
      logic rsp_load;
   } pts_ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] cmd;
      logic       idx_lt_count;
      logic       skip;
      logic       div_done;
      logic       grant_none;
      logic       rsp_free;
   } pts_sts_type;

endpackage

`default_nettype wire

// ===== sv/pts_div.sv =====
// ---------------------------------------------------------------------------
// pts_div : iterative restoring divider
// One quotient bit per cycle; done pulses for one cycle after the last step.
// ---------------------------------------------------------------------------
`default_nettype none

module pts_div #(
   parameter int DW = 33,
   parameter int VW = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [VW-1:0] divisor,
   output logic               done,
   output logic [DW-1:0]      quotient,
   output logic [VW-1:0]      remainder
);

   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] quo_ff, quo_in;
   logic [VW:0]   rem_ff, rem_in;
   logic [VW-1:0] dvs_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [VW:0]   shifted;

   always_comb begin
      shifted = {rem_ff[VW-1:0], quo_ff[DW-1]};
      quo_in  = {quo_ff[DW-2:0], 1'b0};
      rem_in  = shifted;
      if (shifted >= {1'b0, dvs_ff}) begin
         rem_in    = shifted - {1'b0, dvs_ff};
         quo_in[0] = 1'b1;
      end
      cnt_in  = cnt_ff - CW'(1);
      busy_in = (cnt_ff != CW'(1));
      done_in = (cnt_ff == CW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CW'(DW);
      end else if (busy_ff) begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[VW-1:0];

endmodule

`default_nettype wire

// ===== sv/pts_datapath.sv =====
// ---------------------------------------------------------------------------
// pts_datapath : storage and arithmetic of the scheduler
// Action table and due list memories, counters, shared divider and the
// response register, all steered by the controller.
// ---------------------------------------------------------------------------
`default_nettype none

module pts_datapath #(
   parameter int MAX_ACTIONS = pts_pkg::MaxActionsDefault,
   parameter int TIME_BITS   = pts_pkg::TimeBitsDefault
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pts_pkg::pts_req_type req_data,
   input  wire pts_pkg::pts_ctl_type ctl,
   output pts_pkg::pts_sts_type      sts,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output pts_pkg::pts_rsp_type      rsp_data
);

   localparam int CntW = $clog2(MAX_ACTIONS + 1);
   localparam int IdxW = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
   localparam int DivW = (TIME_BITS > 33) ? TIME_BITS : 33;

   pts_pkg::pts_slot_type tbl_mem [MAX_ACTIONS];
   logic [15:0]           due_mem [MAX_ACTIONS];

   pts_pkg::pts_req_type  req_ff;
   pts_pkg::pts_slot_type tbl_rd_ff;
   logic [15:0]           due_rd_ff;
   logic [CntW-1:0]       count_ff, idx_ff, wr_ff, due_total_ff, gi_ff;
   logic [15:0]           fresh_ff;
   logic [31:0]           tick_ff;
   logic [TIME_BITS-1:0]  remain_ff;
   pts_pkg::pts_rsp_type  res_ff, rsp_ff;
   logic                  rsp_valid_ff;

   logic [63:0]           amt_wide;
   logic [TIME_BITS-1:0]  amt, remain_in;
   logic [32:0]           mod_sum;
   logic [CntW-1:0]       pending, gi_in;
   logic [DivW-1:0]       div_dividend, div_quo;
   logic [15:0]           div_divisor, div_rem;
   logic                  div_start, div_done, full;
   logic [63:0]           due_wide, quo_wide;

   always_comb begin
      amt_wide     = {32'b0, req_ff.time_amount};
      amt          = amt_wide[TIME_BITS-1:0];
      remain_in    = (amt >= remain_ff) ? '0 : remain_ff - amt;
      mod_sum      = {1'b0, tick_ff} + {17'b0, tbl_rd_ff.phase};
      pending      = due_total_ff - gi_ff;
      gi_in        = gi_ff + CntW'(1);
      div_start    = ctl.div_mod_start | ctl.next_start;
      div_dividend = ctl.next_start ? DivW'(remain_in) : DivW'(mod_sum);
      div_divisor  = ctl.next_start ? 16'(pending) : tbl_rd_ff.period;
      full         = (count_ff == CntW'(MAX_ACTIONS));
      due_wide     = 64'(due_total_ff);
      quo_wide     = 64'(div_quo);
   end

   pts_div #(
      .DW(DivW),
      .VW(16)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo),
      .remainder(div_rem)
   );

   // memories
   always_ff @(posedge clock) begin
      if (ctl.add_do && !full) begin
         tbl_mem[count_ff[IdxW-1:0]] <= '{id: fresh_ff, period: req_ff.period,
                                          phase: req_ff.phase};
      end
      if (ctl.rm_step && (tbl_rd_ff.id != req_ff.target_id)) begin
         tbl_mem[wr_ff[IdxW-1:0]] <= tbl_rd_ff;
      end
      if (ctl.rd_table) begin
         tbl_rd_ff <= tbl_mem[idx_ff[IdxW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mod_step && div_done && (div_rem == 16'd0)) begin
         due_mem[due_total_ff[IdxW-1:0]] <= tbl_rd_ff.id;
      end
      if (ctl.next_start) begin
         due_rd_ff <= due_mem[gi_ff[IdxW-1:0]];
      end
   end

   // payload holding registers
   always_ff @(posedge clock) begin
      if (ctl.load_req) begin
         req_ff <= req_data;
      end
      if (ctl.scan_init || ctl.tick_init) begin
         idx_ff <= '0;
         wr_ff  <= '0;
      end else if (ctl.rm_step) begin
         idx_ff <= idx_ff + CntW'(1);
         if (tbl_rd_ff.id != req_ff.target_id) begin
            wr_ff <= wr_ff + CntW'(1);
         end
      end else if (ctl.idx_inc) begin
         idx_ff <= idx_ff + CntW'(1);
      end
      if (ctl.add_do) begin
         if (full) begin
            res_ff <= '{status: pts_pkg::StatusFull, default: '0};
         end else begin
            res_ff <= '{status: pts_pkg::StatusOk, action_id: fresh_ff, default: '0};
         end
      end else if (ctl.rm_commit) begin
         res_ff <= '{status: pts_pkg::StatusOk, default: '0};
      end else if (ctl.tick_fin) begin
         res_ff <= '{status: pts_pkg::StatusOk, due_count: due_wide[4:0], default: '0};
      end else if (ctl.nogrant) begin
         res_ff <= '{status: pts_pkg::StatusNoGrant, default: '0};
      end else if (ctl.grant_fin) begin
         res_ff <= '{status: pts_pkg::StatusOk, action_id: due_rd_ff,
                     budget: quo_wide[31:0], due_count: 5'd0,
                     last_grant: (gi_in == due_total_ff)};
      end
      if (ctl.rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         fresh_ff     <= '0;
         tick_ff      <= '0;
         due_total_ff <= '0;
         gi_ff        <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctl.add_do && !full) begin
            count_ff <= count_ff + CntW'(1);
            fresh_ff <= fresh_ff + 16'd1;
         end
         if (ctl.rm_commit) begin
            count_ff <= wr_ff;
         end
         if (ctl.tick_init) begin
            tick_ff      <= tick_ff + 32'd1;
            due_total_ff <= '0;
            gi_ff        <= '0;
            remain_ff    <= amt;
         end
         if (ctl.mod_step && div_done && (div_rem == 16'd0)) begin
            due_total_ff <= due_total_ff + CntW'(1);
         end
         if (ctl.next_start) begin
            remain_ff <= remain_in;
         end
         if (ctl.grant_fin) begin
            gi_ff <= gi_in;
         end
         if (ctl.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      sts.cmd          = req_ff.cmd;
      sts.idx_lt_count = (idx_ff < count_ff);
      sts.skip         = (tbl_rd_ff.period == 16'd0) ||
                         (tick_ff < {16'b0, tbl_rd_ff.period});
      sts.div_done     = div_done;
      sts.grant_none   = (gi_ff >= due_total_ff);
      sts.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== sv/pts_ctrl.sv =====
// ---------------------------------------------------------------------------
// pts_ctrl : sequencing state machine of the scheduler
// Decodes each accepted request and steps the datapath through its scan,
// division and response phases.
// ---------------------------------------------------------------------------
`default_nettype none

module pts_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire pts_pkg::pts_sts_type sts,
   output pts_pkg::pts_ctl_type      ctl
);

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_RM_RD, S_RM_WR, S_TK_RD, S_TK_CHK, S_TK_DIV,
      S_NX_DIV, S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      ctl      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (sts.cmd)
               pts_pkg::CmdAdd: begin
                  ctl.add_do = 1'b1;
                  state_in   = S_DONE;
               end
               pts_pkg::CmdRemove: begin
                  ctl.scan_init = 1'b1;
                  state_in      = S_RM_RD;
               end
               pts_pkg::CmdTick: begin
                  ctl.tick_init = 1'b1;
                  state_in      = S_TK_RD;
               end
               default: begin
                  if (sts.grant_none) begin
                     ctl.nogrant = 1'b1;
                     state_in    = S_DONE;
                  end else begin
                     ctl.next_start = 1'b1;
                     state_in       = S_NX_DIV;
                  end
               end
            endcase
         end
         S_RM_RD: begin
            if (sts.idx_lt_count) begin
               ctl.rd_table = 1'b1;
               state_in     = S_RM_WR;
            end else begin
               ctl.rm_commit = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_RM_WR: begin
            ctl.rm_step = 1'b1;
            state_in    = S_RM_RD;
         end
         S_TK_RD: begin
            if (sts.idx_lt_count) begin
               ctl.rd_table = 1'b1;
               state_in     = S_TK_CHK;
            end else begin
               ctl.tick_fin = 1'b1;
               state_in     = S_DONE;
            end
         end
         S_TK_CHK: begin
            if (sts.skip) begin
               ctl.idx_inc = 1'b1;
               state_in    = S_TK_RD;
            end else begin
               ctl.div_mod_start = 1'b1;
               state_in          = S_TK_DIV;
            end
         end
         S_TK_DIV: begin
            ctl.mod_step = 1'b1;
            if (sts.div_done) begin
               ctl.idx_inc = 1'b1;
               state_in    = S_TK_RD;
            end
         end
         S_NX_DIV: begin
            if (sts.div_done) begin
               ctl.grant_fin = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               ctl.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

`default_nettype wire

// ===== sv/phased_periodic_task_scheduler.sv =====
// ---------------------------------------------------------------------------
// phased_periodic_task_scheduler : periodic action table with phased due test
// Add, remove, tick and grant commands over an ordered table of actions;
// grants share the tick's time budget among the actions found due.
// ---------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req_     in         req_valid / req_ready  pts_req_type (cmd .. time_amount)
//  rsp_     out        rsp_valid / rsp_ready  pts_rsp_type (status .. last_grant)
//
//  Add fills one table slot unless the table is full; remove reads each entry
//  and writes back the ones it keeps. Tick reads each entry and runs the modulo
//  test on the bit-serial shared divider for each entry that is not skipped.
//  Next runs one division on the same divider (DivW = max(33, TIME_BITS)).
//  Reset is synchronous and clears counters and control only; no clearing pass
//  is run. A result beat waits in its own register, so a new request beat is
//  taken while the previous response is still stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module phased_periodic_task_scheduler #(
   parameter int MAX_ACTIONS = pts_pkg::MaxActionsDefault,
   parameter int TIME_BITS   = pts_pkg::TimeBitsDefault
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire pts_pkg::pts_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output pts_pkg::pts_rsp_type      rsp_data
);

   pts_pkg::pts_ctl_type ctl;
   pts_pkg::pts_sts_type sts;

   // sequence each command
   pts_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .sts      (sts),
      .ctl      (ctl)
   );

   // hold the table, due list, counters and response beat
   pts_datapath #(
      .MAX_ACTIONS(MAX_ACTIONS),
      .TIME_BITS  (TIME_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .ctl      (ctl),
      .sts      (sts),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb : self-checking bench for the phased periodic task scheduler
// Drives directed and random add, remove, tick and next beats with bursty
// request timing and a stalling response side; checks every response beat
// against a behavioural model of the action table and grant sequence.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int NumActions = pts_pkg::MaxActionsDefault;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   pts_pkg::pts_req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   pts_pkg::pts_rsp_type rsp_data;

   phased_periodic_task_scheduler u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // model state of the scheduler
   pts_pkg::pts_slot_type sched_table [NumActions];
   int unsigned           sched_count;
   logic [15:0]           sched_fresh_id;
   logic [31:0]           sched_tick;
   logic [15:0]           sched_due [NumActions];
   int unsigned           sched_due_total;
   int unsigned           sched_grant_idx;
   logic [31:0]           sched_remaining;

   pts_pkg::pts_rsp_type  rsp_pending_q [$];
   int                    error_count;

   // directed rows: request plus optional typed-in response
   typedef struct {
      pts_pkg::pts_req_type req;
      bit                   fixed;
      pts_pkg::pts_rsp_type rsp;
   } stim_row_type;

   function automatic pts_pkg::pts_rsp_type sched_step(pts_pkg::pts_req_type rq);
      pts_pkg::pts_rsp_type r;
      int unsigned w;
      logic [31:0] p;
      logic [32:0] sum;
      r = '0;
      case (rq.cmd)
         pts_pkg::CmdAdd: begin
            if (sched_count >= NumActions) begin
               r.status = pts_pkg::StatusFull;
            end else begin
               sched_table[sched_count] = '{sched_fresh_id, rq.period, rq.phase};
               sched_count++;
               r.action_id = sched_fresh_id;
               sched_fresh_id = sched_fresh_id + 16'd1;
            end
         end
         pts_pkg::CmdRemove: begin
            w = 0;
            for (int i = 0; i < sched_count; i++)
               if (sched_table[i].id != rq.target_id) begin
                  sched_table[w] = sched_table[i];
                  w++;
               end
            sched_count = w;
         end
         pts_pkg::CmdTick: begin
            sched_tick = sched_tick + 32'd1;
            sched_due_total = 0;
            for (int i = 0; i < sched_count; i++) begin
               p = {16'd0, sched_table[i].period};
               if (p == 0 || sched_tick < p) continue;
               sum = {1'b0, sched_tick} + {17'd0, sched_table[i].phase};
               if (sum % {1'b0, p} == 0) begin
                  sched_due[sched_due_total] = sched_table[i].id;
                  sched_due_total++;
               end
            end
            sched_grant_idx = 0;
            sched_remaining = rq.time_amount;
            r.due_count = 5'(sched_due_total);
         end
         default: begin
            if (sched_grant_idx >= sched_due_total) begin
               r.status = pts_pkg::StatusNoGrant;
            end else begin
               if (rq.time_amount >= sched_remaining) sched_remaining = '0;
               else sched_remaining = sched_remaining - rq.time_amount;
               r.budget = sched_remaining / (sched_due_total - sched_grant_idx);
               r.action_id = sched_due[sched_grant_idx];
               sched_grant_idx++;
               r.last_grant = (sched_grant_idx == sched_due_total);
            end
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("DONE: errors detected");
      $finish;
   end

   // response side: stall on its own pattern, check each beat at the rising edge
   int stall_mode;
   initial begin
      rsp_ready = 1'b0;
      stall_mode = 0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      pts_pkg::pts_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_pending_q.size() == 0) begin
            report_mismatch("unexpected beat", 32'(rsp_data.status), 0);
         end else begin
            want = rsp_pending_q.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
            if (rsp_data.action_id !== want.action_id)
               report_mismatch("action_id", 32'(rsp_data.action_id), 32'(want.action_id));
            if (rsp_data.budget !== want.budget)
               report_mismatch("budget", rsp_data.budget, want.budget);
            if (rsp_data.due_count !== want.due_count)
               report_mismatch("due_count", 32'(rsp_data.due_count), 32'(want.due_count));
            if (rsp_data.last_grant !== want.last_grant)
               report_mismatch("last_grant", 32'(rsp_data.last_grant),
                               32'(want.last_grant));
         end
      end
   end

   // send one request beat, then predict its response
   task automatic send_beat(pts_pkg::pts_req_type rq, bit fixed,
                            pts_pkg::pts_rsp_type fixed_rsp);
      pts_pkg::pts_rsp_type pred;
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (!req_ready);
      pred = sched_step(rq);
      if (fixed && pred !== fixed_rsp)
         report_mismatch("model vs table", 32'(pred), 32'(fixed_rsp));
      rsp_pending_q.insert(rsp_pending_q.size(), pred);
      @(negedge clock);
   endtask

   function automatic pts_pkg::pts_req_type rand_req();
      pts_pkg::pts_req_type rq;
      int                   sel;
      rq.cmd = 2'($urandom_range(0, 3));
      sel = $urandom_range(0, 9);
      // mostly short periods so actions actually come due
      rq.period = (sel < 7) ? 16'($urandom_range(0, 6))
                            : (sel < 9 ? 16'($urandom) : 16'hFFFF);
      rq.phase = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
      // remove targets near recently handed-out ids, sometimes anything
      rq.target_id = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                   : sched_fresh_id - 16'($urandom_range(1, 20));
      rq.time_amount = ($urandom_range(0, 2) == 0) ? $urandom : 32'($urandom_range(0, 1000));
      return rq;
   endfunction

   function automatic pts_pkg::pts_req_type mk(logic [1:0] c, logic [15:0] per,
                                               logic [15:0] ph, logic [15:0] tid,
                                               logic [31:0] amt);
      pts_pkg::pts_req_type rq;
      rq = '{c, per, ph, tid, amt};
      return rq;
   endfunction

   initial begin
      stim_row_type         rows [$];
      stim_row_type         row;
      pts_pkg::pts_rsp_type none;
      int                   gap;
      int                   burst;
      int                   wait_cycles;

      error_count = 0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      none      = '0;
      sched_count = 0; sched_fresh_id = '0; sched_tick = '0;
      sched_due_total = 0; sched_grant_idx = 0; sched_remaining = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: next before any tick, adds, remove of unknown id, ticks, grants
      rows.insert(rows.size(), '{mk(pts_pkg::CmdNext, 0, 0, 0, 32'hFFFFFFFF), 1,
                                 '{pts_pkg::StatusNoGrant, 0, 0, 0, 0}});
      rows.insert(rows.size(), '{mk(pts_pkg::CmdAdd, 1, 0, 0, 0), 1,
                                 '{pts_pkg::StatusOk, 16'd0, 0, 0, 0}});
      rows.insert(rows.size(), '{mk(pts_pkg::CmdAdd, 0, 16'hFFFF, 0, 0), 1,
                                 '{pts_pkg::StatusOk, 16'd1, 0, 0, 0}});
      rows.insert(rows.size(), '{mk(pts_pkg::CmdAdd, 16'hFFFF, 16'hFFFF, 0, 0), 1,
                                 '{pts_pkg::StatusOk, 16'd2, 0, 0, 0}});
      rows.insert(rows.size(), '{mk(pts_pkg::CmdAdd, 2, 1, 0, 0), 0, none});
      rows.insert(rows.size(), '{mk(pts_pkg::CmdRemove, 0, 0, 16'hFFFF, 0), 1,
                                 '{pts_pkg::StatusOk, 0, 0, 0, 0}});
      rows.insert(rows.size(), '{mk(pts_pkg::CmdTick, 0, 0, 0, 32'hFFFFFFFF), 0, none});
      rows.insert(rows.size(), '{mk(pts_pkg::CmdNext, 0, 0, 0, 0), 0, none});
      rows.insert(rows.size(), '{mk(pts_pkg::CmdNext, 0, 0, 0, 0), 0, none});
      rows.insert(rows.size(), '{mk(pts_pkg::CmdNext, 0, 0, 0, 0), 0, none});
      rows.insert(rows.size(), '{mk(pts_pkg::CmdTick, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1000),
                                 0, none});
      rows.insert(rows.size(), '{mk(pts_pkg::CmdRemove, 0, 0, 16'd3, 0), 0, none});
      rows.insert(rows.size(), '{mk(pts_pkg::CmdNext, 0, 0, 0, 32'hFFFFFFFF), 0, none});
      rows.insert(rows.size(), '{mk(pts_pkg::CmdNext, 0, 0, 0, 0), 0, none});
      for (int i = 0; i < 14; i++)
         rows.insert(rows.size(), '{mk(pts_pkg::CmdAdd, 1, 0, 0, 0), 0, none});
      rows.insert(rows.size(), '{mk(pts_pkg::CmdAdd, 1, 0, 0, 0), 1,
                                 '{pts_pkg::StatusFull, 0, 0, 0, 0}});
      rows.insert(rows.size(), '{mk(pts_pkg::CmdTick, 0, 0, 0, 32'd17), 1,
                                 '{pts_pkg::StatusOk, 0, 0, 5'd14, 0}});
      foreach (rows[i]) send_beat(rows[i].req, rows[i].fixed, rows[i].rsp);
      req_valid <= 1'b0;

      // hold off until the directed part has fully drained
      while (rsp_pending_q.size() != 0) @(negedge clock);

      // random bursts; when the table is full, often remove an entry to keep adds succeeding
      for (int n = 0; n < 1200; ) begin
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst; b++, n++) begin
            if (sched_count == NumActions && $urandom_range(0, 1))
               send_beat(mk(pts_pkg::CmdRemove, 0, 0,
                            sched_table[$urandom_range(0, NumActions - 1)].id, 0),
                         0, none);
            else
               send_beat(rand_req(), 0, none);
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
         // drop valid when the next beat does not follow at once, or to drain mid-run
         if (gap > 0 || (n > 600 && n < 620)) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
            if (n > 600 && n < 620)
               while (rsp_pending_q.size() != 0) @(negedge clock);
         end
      end
      req_valid <= 1'b0;

      wait_cycles = 0;
      while (rsp_pending_q.size() != 0 && wait_cycles < 100000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (100) @(negedge clock);
      if (error_count == 0 && rsp_pending_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/pts_pkg.sv
sv/pts_div.sv
sv/pts_datapath.sv
sv/pts_ctrl.sv
sv/phased_periodic_task_scheduler.sv
tb/tb.sv
